@@ rtl/gri_pkg.sv @@
package gri_pkg;

  // Response frame status field: bits 27:26 of the word, bits 3:2 of the first byte
  localparam logic [7:0] STATUS_MASK = 8'h0C;
  localparam logic [7:0] STATUS_GOOD = 8'h04;

  // Item operations
  localparam logic OP_FRAME = 1'b0;
  localparam logic OP_LOAD  = 1'b1;

  // Register indexes on the configuration port
  localparam logic REG_MODE  = 1'b0;
  localparam logic REG_SCALE = 1'b1;

  localparam int RATE_W  = 16;
  localparam int ANGLE_W = 48;
  localparam int SCALE_W = 32;
  localparam int FRAC_W  = 16;

  typedef enum logic [1:0] {
    TS_IDLE,
    TS_WIN,
    TS_STAT,
    TS_OUT
  } top_state_t;

  typedef enum logic [2:0] {
    SS_IDLE,
    SS_SQR,
    SS_QUAD,
    SS_MAC,
    SS_DIV
  } stat_state_t;

  typedef struct packed {
    logic busy;
    logic done;
  } unit_sts_t;

endpackage

@@ rtl/gri_if.sv @@
interface gri_in_if;
  logic               valid;
  logic               ready;
  logic               operation;
  logic [31:0]        frame_word;
  logic signed [47:0] angle_load;

  modport source (output valid, operation, frame_word, angle_load, input ready);
  modport sink (input valid, operation, frame_word, angle_load, output ready);
endinterface

interface gri_out_if;
  logic               valid;
  logic               ready;
  logic               frame_ok;
  logic signed [47:0] angle;
  logic signed [15:0] rate;
  logic signed [15:0] bias_offset;
  logic [47:0]        bias_spread;

  modport source (output valid, frame_ok, angle, rate, bias_offset, bias_spread, input ready);
  modport sink (input valid, frame_ok, angle, rate, bias_offset, bias_spread, output ready);
endinterface

@@ rtl/gri_div.sv @@
module gri_div import gri_pkg::*; #(
  parameter int DW = 8,
  parameter int VW = 8
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [DW-1:0] dividend,
  input  logic [VW-1:0] divisor,
  output logic [DW-1:0] quotient,
  output unit_sts_t     sts
);

  localparam int CNT_W = $clog2(DW + 1);

  logic [DW-1:0]    quo;
  logic [VW-1:0]    rem;
  logic [CNT_W-1:0] steps;
  logic             busy;
  logic             done;
  logic [VW:0]      trial;
  logic [VW:0]      diff;
  logic             fits;

  // Restoring division, one quotient bit a cycle, MSB first
  assign trial = {rem, quo[DW-1]};
  assign diff  = trial - {1'b0, divisor};
  assign fits  = (trial >= {1'b0, divisor});

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      steps <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        steps <= CNT_W'(DW);
      end else if (busy) begin
        steps <= steps - 1'b1;
        if (steps == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo <= dividend;
      rem <= '0;
    end else if (busy) begin
      rem <= fits ? diff[VW-1:0] : trial[VW-1:0];
      quo <= {quo[DW-2:0], fits};
    end
  end

  assign quotient = quo;
  assign sts      = '{busy: busy, done: done};

endmodule

@@ rtl/gri_window.sv @@
module gri_window import gri_pkg::*; #(
  parameter int WL    = 101,
  parameter int CW    = $clog2(WL + 1),
  parameter int SUM_W = CW + 16,
  parameter int SQ_W  = CW + 31
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    add,
  input  logic signed [RATE_W-1:0] sample,
  output logic signed [SUM_W-1:0] sum,
  output logic [SQ_W-1:0]         sq,
  output logic [CW-1:0]           count,
  output unit_sts_t               sts
);

  localparam int AW = $clog2(WL);

  logic signed [RATE_W-1:0] mem [WL];
  logic signed [RATE_W-1:0] rd_data;
  logic signed [RATE_W-1:0] smp;
  logic signed [RATE_W-1:0] old;
  logic [AW-1:0]            oldest;
  logic [AW-1:0]            slot;
  logic                     pend;
  logic                     full_q;
  logic                     done;
  logic                     full;
  logic [AW:0]              pos;
  logic [AW:0]              pos_wrap;
  logic signed [31:0]       p_new;
  logic signed [31:0]       p_old;

  assign full     = (count == CW'(WL));
  assign pos      = (AW+1)'(oldest) + (AW+1)'(count);
  assign pos_wrap = (pos >= (AW+1)'(WL)) ? pos - (AW+1)'(WL) : pos;
  // Only a full window evicts: drop the oldest sample from the sums
  assign old      = full_q ? rd_data : '0;
  assign p_new    = smp * smp;
  assign p_old    = old * old;

  // Read the oldest entry every cycle; the data lands in the next cycle
  always_ff @(posedge clk) begin
    rd_data <= mem[oldest];
    if (pend) begin
      mem[slot] <= smp;
    end
  end

  always_ff @(posedge clk) begin
    if (add) begin
      smp    <= sample;
      full_q <= full;
      slot   <= full ? oldest : pos_wrap[AW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pend   <= 1'b0;
      done   <= 1'b0;
      count  <= '0;
      oldest <= '0;
      sum    <= '0;
      sq     <= '0;
    end else begin
      pend <= add;
      done <= pend;
      if (pend) begin
        sum <= sum - SUM_W'(old) + SUM_W'(smp);
        sq  <= sq - SQ_W'($unsigned(p_old)) + SQ_W'($unsigned(p_new));
        if (full_q) begin
          oldest <= (oldest == AW'(WL - 1)) ? '0 : oldest + 1'b1;
        end else begin
          count <= count + 1'b1;
        end
      end
    end
  end

  assign sts = '{busy: pend, done: done};

endmodule

@@ rtl/gri_stats.sv @@
module gri_stats import gri_pkg::*; #(
  parameter int WL    = 101,
  parameter int CW    = $clog2(WL + 1),
  parameter int SUM_W = CW + 16,
  parameter int SQ_W  = CW + 31
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  input  logic signed [SUM_W-1:0]  sum,
  input  logic [SQ_W-1:0]          sq,
  input  logic [CW-1:0]            count,
  output logic signed [RATE_W-1:0] offset,
  output logic [ANGLE_W-1:0]       spread,
  output unit_sts_t                sts
);

  localparam int N2_W  = 2 * CW;
  localparam int N4_W  = 4 * CW;
  localparam int NUM_W = SQ_W + N2_W;
  localparam int DVD_W = NUM_W + FRAC_W;

  stat_state_t state, state_next;

  logic [CW-1:0]           n;
  logic signed [SUM_W-1:0] s;
  logic [SQ_W-1:0]         sqv;
  logic [N2_W-1:0]         n2;
  logic [N4_W-1:0]         n4;
  logic [NUM_W-1:0]        s2;
  logic [NUM_W-1:0]        acc;
  logic [NUM_W-1:0]        mcand;
  logic [N2_W-1:0]         mplier;
  logic [SUM_W-1:0]        mag;
  logic                    neg;
  logic                    done;
  logic                    div_start;
  logic [NUM_W-1:0]        num;
  logic [SUM_W-1:0]        mean_q;
  logic [DVD_W-1:0]        spread_q;
  logic signed [2*SUM_W-1:0] s_sq;
  unit_sts_t               mean_sts;
  unit_sts_t               spread_sts;

  assign s_sq = s * s;
  // The variance numerator is never negative in exact arithmetic; clamp anyway
  assign num  = (acc >= s2) ? acc - s2 : '0;

  always_comb begin
    state_next = state;
    case (state)
      SS_IDLE: if (start) state_next = SS_SQR;
      SS_SQR:  state_next = SS_QUAD;
      SS_QUAD: state_next = SS_MAC;
      SS_MAC:  if (mplier == '0) state_next = SS_DIV;
      SS_DIV:  if (spread_sts.done) state_next = SS_IDLE;
      default: state_next = SS_IDLE;
    endcase
  end

  always_comb begin
    div_start = 1'b0;
    case (state)
      SS_MAC:  div_start = (mplier == '0);
      default: div_start = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= SS_IDLE;
      done   <= 1'b0;
      offset <= '0;
      spread <= '0;
    end else begin
      state <= state_next;
      done  <= (state == SS_DIV) && spread_sts.done;
      if (mean_sts.done) begin
        offset <= neg ? -RATE_W'(mean_q) : RATE_W'(mean_q);
      end
      if (spread_sts.done) begin
        spread <= ANGLE_W'(spread_q);
      end
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      SS_IDLE: begin
        n   <= count;
        s   <= sum;
        sqv <= sq;
      end
      SS_SQR: begin
        n2  <= N2_W'(n) * N2_W'(n);
        s2  <= NUM_W'($unsigned(s_sq));
        neg <= s[SUM_W-1];
        mag <= s[SUM_W-1] ? $unsigned(-s) : $unsigned(s);
      end
      SS_QUAD: begin
        n4     <= N4_W'(n2) * N4_W'(n2);
        acc    <= '0;
        mcand  <= NUM_W'(sqv);
        mplier <= n2;
      end
      SS_MAC: begin
        // Shift-add: one bit of n*n a cycle
        if (mplier != '0) begin
          if (mplier[0]) begin
            acc <= acc + mcand;
          end
          mcand  <= {mcand[NUM_W-2:0], 1'b0};
          mplier <= {1'b0, mplier[N2_W-1:1]};
        end
      end
      default: begin
      end
    endcase
  end

  gri_div #(.DW(SUM_W), .VW(CW)) u_mean_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (mag),
    .divisor  (n),
    .quotient (mean_q),
    .sts      (mean_sts)
  );

  gri_div #(.DW(DVD_W), .VW(N4_W)) u_spread_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend ({num, {FRAC_W{1'b0}}}),
    .divisor  (n4),
    .quotient (spread_q),
    .sts      (spread_sts)
  );

  assign sts = '{busy: (state != SS_IDLE), done: done};

endmodule

@@ rtl/gyro_rate_integrator_with_calibration.sv @@
// Gyro rate integrator with a bias calibration window. Each item either loads the
// angle or carries one 32-bit sensor response frame; every item yields exactly one
// result item. A frame counts only if both odd-parity checks pass and the status
// field is 1; otherwise nothing changes. Outside calibration the corrected rate
// times rate_scale is added to the angle, and the item then passes through the output
// step. In calibration the rate enters a WINDOW_LENGTH-deep sample memory (read,
// modify, write back) and a sequencer then forms the mean and the spread; the
// spread's divider works serially, one quotient bit a cycle, over
// 3*clog2(WINDOW_LENGTH+1)+47 bits. One item is in work at a time; the next is taken
// while the last result still waits on the output register. The window memory is
// never cleared.
module gyro_rate_integrator_with_calibration import gri_pkg::*; #(
  parameter int WINDOW_LENGTH = 101
) (
  input  logic        clk,
  input  logic        rst,
  gri_in_if.sink      sample,
  gri_out_if.source   result,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int CW    = $clog2(WINDOW_LENGTH + 1);
  localparam int SUM_W = CW + 16;
  localparam int SQ_W  = CW + 31;

  top_state_t state, state_next;

  logic                      cal_mode;
  logic signed [SCALE_W-1:0] rate_scale;
  logic signed [ANGLE_W-1:0] angle_acc;
  logic signed [RATE_W-1:0]  last_rate;
  logic                      ok;

  logic [7:0]                b0, b1, b2, b3;
  logic                      frame_good;
  logic signed [RATE_W-1:0]  raw;
  logic signed [RATE_W-1:0]  corr;
  logic signed [ANGLE_W-1:0] prod;
  logic                      accepted;
  logic                      win_add;
  logic                      stat_start;
  logic                      out_load;
  logic                      reg_sel;

  logic signed [SUM_W-1:0]   win_sum;
  logic [SQ_W-1:0]           win_sq;
  logic [CW-1:0]             win_count;
  unit_sts_t                 win_sts;
  unit_sts_t                 stat_sts;
  logic signed [RATE_W-1:0]  offset;
  logic [ANGLE_W-1:0]        spread;

  // Frame decode: first byte in the top bits
  assign b0         = sample.frame_word[31:24];
  assign b1         = sample.frame_word[23:16];
  assign b2         = sample.frame_word[15:8];
  assign b3         = sample.frame_word[7:0];
  assign frame_good = (^(b0 ^ b1)) && (^(b0 ^ b1 ^ b2 ^ b3)) &&
                      ((b0 & STATUS_MASK) == STATUS_GOOD);
  assign raw        = sample.frame_word[25:10];
  assign corr       = raw - offset;
  assign prod       = ANGLE_W'(corr) * ANGLE_W'(rate_scale);
  assign accepted   = sample.valid && sample.ready;

  // Configuration port: every access completes at once
  assign pready  = 1'b1;
  assign reg_sel = paddr[2];

  always_comb begin
    case (reg_sel)
      REG_MODE:  prdata = {31'b0, cal_mode};
      REG_SCALE: prdata = rate_scale;
      default:   prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cal_mode   <= 1'b0;
      rate_scale <= '0;
    end else if (psel && penable && pwrite) begin
      case (reg_sel)
        REG_MODE:  cal_mode <= pwdata[0];
        REG_SCALE: rate_scale <= pwdata;
        default:   cal_mode <= cal_mode;
      endcase
    end
  end

  // Sequence: an item in idle, then window update and statistics for a
  // calibration frame, then hand the result to the output register
  always_comb begin
    state_next = state;
    case (state)
      TS_IDLE: begin
        if (accepted) begin
          if (sample.operation == OP_FRAME && frame_good && cal_mode) begin
            state_next = TS_WIN;
          end else begin
            state_next = TS_OUT;
          end
        end
      end
      TS_WIN:  if (win_sts.done) state_next = TS_STAT;
      TS_STAT: if (stat_sts.done) state_next = TS_OUT;
      TS_OUT:  if (!result.valid || result.ready) state_next = TS_IDLE;
      default: state_next = TS_IDLE;
    endcase
  end

  always_comb begin
    sample.ready = 1'b0;
    win_add      = 1'b0;
    stat_start   = 1'b0;
    out_load     = 1'b0;
    case (state)
      TS_IDLE: begin
        sample.ready = 1'b1;
        win_add      = sample.valid && (sample.operation == OP_FRAME) &&
                       frame_good && cal_mode;
      end
      TS_WIN:  stat_start = win_sts.done;
      TS_OUT:  out_load = !result.valid || result.ready;
      default: sample.ready = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= TS_IDLE;
      angle_acc    <= '0;
      last_rate    <= '0;
      ok           <= 1'b0;
      result.valid <= 1'b0;
    end else begin
      state <= state_next;
      if (accepted) begin
        ok <= 1'b0;
        if (sample.operation == OP_LOAD) begin
          angle_acc <= sample.angle_load;
        end else if (frame_good) begin
          ok <= 1'b1;
          if (cal_mode) begin
            // Raw rate in calibration; the window sets the offset
            last_rate <= raw;
          end else begin
            last_rate <= corr;
            angle_acc <= angle_acc + prod;
          end
        end
      end
      if (out_load) begin
        result.valid <= 1'b1;
      end else if (result.ready) begin
        result.valid <= 1'b0;
      end
    end
  end

  // Hold the result payload until taken
  always_ff @(posedge clk) begin
    if (out_load) begin
      result.frame_ok    <= ok;
      result.angle       <= angle_acc;
      result.rate        <= last_rate;
      result.bias_offset <= offset;
      result.bias_spread <= spread;
    end
  end

  gri_window #(.WL(WINDOW_LENGTH), .CW(CW), .SUM_W(SUM_W), .SQ_W(SQ_W)) u_window (
    .clk    (clk),
    .rst    (rst),
    .add    (win_add),
    .sample (raw),
    .sum    (win_sum),
    .sq     (win_sq),
    .count  (win_count),
    .sts    (win_sts)
  );

  gri_stats #(.WL(WINDOW_LENGTH), .CW(CW), .SUM_W(SUM_W), .SQ_W(SQ_W)) u_stats (
    .clk    (clk),
    .rst    (rst),
    .start  (stat_start),
    .sum    (win_sum),
    .sq     (win_sq),
    .count  (win_count),
    .offset (offset),
    .spread (spread),
    .sts    (stat_sts)
  );

`ifndef SYNTHESIS
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    accepted |=> !sample.ready)
    else $error("item accepted while another is in work");

  a_result_from_out: assert property (@(posedge clk) disable iff (rst)
    $rose(result.valid) |-> $past(state == TS_OUT))
    else $error("result raised outside the output step");

  a_units_exclusive: assert property (@(posedge clk) disable iff (rst)
    !(win_sts.busy && stat_sts.busy))
    else $error("window and statistics active together");

  a_window_done: assert property (@(posedge clk) disable iff (rst)
    win_sts.done |-> (state == TS_WIN))
    else $error("window update finished outside its step");
`endif

endmodule

@@ bench/gri_checker.sv @@
`timescale 1ns / 1ps

module gri_checker import gri_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  gri_in_if           sample,
  gri_out_if          result,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  input  logic        pready,
  output int          mismatches,
  output int          outstanding
);

  localparam int WINDOW_LENGTH = 101;
  localparam logic [2:0] ADDR_MODE  = 3'(REG_MODE) << 2;
  localparam logic [2:0] ADDR_SCALE = 3'(REG_SCALE) << 2;

  typedef struct packed {
    logic        frame_ok;
    logic [47:0] angle;
    logic [15:0] rate;
    logic [15:0] bias_offset;
    logic [47:0] bias_spread;
  } reading_t;

  reading_t expected_readings[$];

  // Shadow copy of the block's state and registers
  logic signed [15:0] window_mem [WINDOW_LENGTH];
  int                 win_count;
  int                 win_oldest;
  longint             win_sum;
  logic [63:0]        win_sq;
  logic [47:0]        angle_acc;
  logic signed [15:0] last_rate;
  logic signed [15:0] offset;
  logic [47:0]        spread;
  bit                 prev_mode;
  bit                 cal_mode;
  logic signed [31:0] scale;

  function automatic reading_t predict_reading(logic op, logic [31:0] w, logic [47:0] ld);
    reading_t           r;
    logic [7:0]         b0, b1, b2, b3;
    bit                 ok;
    logic signed [15:0] raw, oldv;
    longint             prod;
    int                 slot;
    logic [63:0]        n, n2, n4, s2, num, q, rm;
    ok = 0;
    if (op == OP_LOAD) begin
      angle_acc = ld;
    end else begin
      {b0, b1, b2, b3} = w;
      ok = (^(b0 ^ b1)) && (^w) && ((b0 & STATUS_MASK) == STATUS_GOOD);
      if (ok) begin
        raw = w[25:10];
        // entering calibration seeds the offset with the raw rate
        if (cal_mode && !prev_mode) offset = raw;
        prev_mode = cal_mode;
        if (cal_mode) begin
          last_rate = raw;
          if (win_count >= WINDOW_LENGTH) begin
            oldv = window_mem[win_oldest];
            win_sum -= oldv;
            win_sq -= 64'(longint'(oldv) * longint'(oldv));
            slot = win_oldest;
            win_oldest = (win_oldest + 1) % WINDOW_LENGTH;
          end else begin
            slot = (win_oldest + win_count) % WINDOW_LENGTH;
            win_count++;
          end
          window_mem[slot] = raw;
          win_sum += raw;
          win_sq += 64'(longint'(raw) * longint'(raw));
          n = win_count;
          n2 = n * n;
          n4 = n2 * n2;
          s2 = 64'(win_sum * win_sum);
          num = win_sq * n2;
          offset = 16'(win_sum / longint'(win_count));
          num = (num >= s2) ? num - s2 : 64'd0;
          q = num / n4;
          rm = num % n4;
          spread = 48'((q << 16) | ((rm << 16) / n4));
        end else begin
          last_rate = raw - offset;
          prod = longint'(last_rate) * longint'(scale);
          angle_acc = angle_acc + 48'(prod);
        end
      end
    end
    r = '{ok, angle_acc, last_rate, offset, spread};
    return r;
  endfunction

  always @(posedge clk) begin
    reading_t want;
    int       errs;
    errs = 0;
    if (rst) begin
      expected_readings.delete();
      win_count <= 0;
      win_oldest <= 0;
      win_sum <= 0;
      win_sq <= '0;
      angle_acc <= '0;
      last_rate <= '0;
      offset <= '0;
      spread <= '0;
      prev_mode <= 0;
      cal_mode <= 0;
      scale <= '0;
      mismatches <= 0;
      outstanding <= 0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        if (paddr == ADDR_MODE) cal_mode = pwdata[0];
        else if (paddr == ADDR_SCALE) scale = pwdata;
      end
      // check the outgoing item before queuing a new prediction
      if (result.valid && result.ready) begin
        if (expected_readings.size() == 0) begin
          $error("result item with no expectation pending");
          errs++;
        end else begin
          want = expected_readings.pop_front();
          if (result.frame_ok !== want.frame_ok) begin
            $error("frame_ok expected %0b actual %0b", want.frame_ok, result.frame_ok);
            errs++;
          end
          if (result.angle !== want.angle) begin
            $error("angle expected %h actual %h", want.angle, result.angle);
            errs++;
          end
          if (result.rate !== want.rate) begin
            $error("rate expected %h actual %h", want.rate, result.rate);
            errs++;
          end
          if (result.bias_offset !== want.bias_offset) begin
            $error("bias_offset expected %h actual %h", want.bias_offset, result.bias_offset);
            errs++;
          end
          if (result.bias_spread !== want.bias_spread) begin
            $error("bias_spread expected %h actual %h", want.bias_spread, result.bias_spread);
            errs++;
          end
        end
      end
      mismatches <= mismatches + errs;
      if (sample.valid && sample.ready)
        expected_readings.push_back(predict_reading(sample.operation, sample.frame_word,
                                                    sample.angle_load));
      outstanding <= expected_readings.size();
    end
  end

endmodule

@@ bench/testbench.sv @@
`timescale 1ns / 1ps

module testbench;
  import gri_pkg::*;

  localparam int CYCLE_LIMIT = 600000;
  // drain time after the last result
  localparam int DRAIN_CYCLES = 150;

  logic        clk;
  logic        rst;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;
  int          mismatches;
  int          outstanding;
  int          cycles;
  int          items_sent;
  bit          quiet;

  gri_in_if  sample_ch();
  gri_out_if result_ch();

  gyro_rate_integrator_with_calibration uut (
    .clk(clk), .rst(rst), .sample(sample_ch), .result(result_ch),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  gri_checker scoreboard (
    .clk(clk), .rst(rst), .sample(sample_ch), .result(result_ch),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .pready(pready), .mismatches(mismatches), .outstanding(outstanding)
  );

  // 4 ns clock
  always begin
    clk = 1'b1;
    #2;
    clk = 1'b0;
    #2;
  end

  // Watchdog: bail out if the run hangs
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  // Receiver: stall at random about 14 percent of the time unless in a quiet stretch
  always @(negedge clk) begin
    result_ch.ready <= quiet || ($urandom_range(99) >= 14);
  end

  // Write one register through a setup and an access phase
  task automatic write_reg(logic reg_index, logic [31:0] value);
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= 3'(reg_index) << 2;
    pwdata <= value;
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  // Drop valid, hold until every expected result is back, then let the block go idle
  task automatic settle();
    @(negedge clk);
    sample_ch.valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Present one item; return once it has been accepted
  task automatic send_item(logic op, logic [31:0] word, logic [47:0] load);
    @(negedge clk);
    while (!quiet && $urandom_range(99) < 14) begin
      sample_ch.valid <= 1'b0;
      @(negedge clk);
    end
    sample_ch.valid <= 1'b1;
    sample_ch.operation <= op;
    sample_ch.frame_word <= word;
    sample_ch.angle_load <= load;
    do @(posedge clk); while (!sample_ch.ready);
    items_sent++;
  endtask

  // Build a well-formed frame around a rate: status 1, both parities odd
  function automatic logic [31:0] make_frame(logic [15:0] rate_value);
    logic [31:0] w;
    w = $urandom;
    w[27:26] = 2'b01;
    w[25:10] = rate_value;
    if (!(^(w[31:24] ^ w[23:16]))) w[28] = ~w[28];
    if (!(^w)) w[0] = ~w[0];
    return w;
  endfunction

  function automatic logic [15:0] pick_rate();
    case ($urandom_range(7))
      0: return 16'h7FFF;
      1: return 16'h8000;
      2: return 16'($signed($urandom_range(64)) - 32);
      default: return 16'($urandom);
    endcase
  endfunction

  // Mostly good frames with random content, the rest loads, noise and broken frames
  task automatic random_item();
    int          pick;
    logic [31:0] w;
    pick = $urandom_range(99);
    if (pick < 8) begin
      send_item(OP_LOAD, $urandom, 48'({$urandom, $urandom}));
    end else if (pick < 16) begin
      send_item(OP_FRAME, $urandom, 48'({$urandom, $urandom}));
    end else if (pick < 22) begin
      w = make_frame(pick_rate());
      case ($urandom_range(2))
        0: w[16] = ~w[16];
        1: w[0] = ~w[0];
        default: w[27:26] = 2'(1 + $urandom_range(2));
      endcase
      send_item(OP_FRAME, w, 48'({$urandom, $urandom}));
    end else begin
      send_item(OP_FRAME, make_frame(pick_rate()), 48'({$urandom, $urandom}));
    end
  endtask

  task automatic random_burst(int count);
    for (int i = 0; i < count; i++) random_item();
  endtask

  initial begin
    logic [31:0] w;
    rst = 1'b1;
    cycles = 0;
    items_sent = 0;
    quiet = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    sample_ch.valid = 1'b0;
    sample_ch.operation = OP_FRAME;
    sample_ch.frame_word = '0;
    sample_ch.angle_load = '0;
    result_ch.ready = 1'b0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed: integrate with rate_scale 32'h0100_0000
    write_reg(REG_SCALE, 32'h0100_0000);
    write_reg(REG_MODE, 32'd0);
    send_item(OP_LOAD, '0, 48'h7FFF_FFFF_FFFF);
    send_item(OP_FRAME, make_frame(16'h7FFF), '0);
    send_item(OP_LOAD, '0, 48'h8000_0000_0000);
    send_item(OP_FRAME, make_frame(16'h8000), '0);
    send_item(OP_FRAME, make_frame(16'h0000), '0);
    send_item(OP_FRAME, 32'h0000_0000, '0);
    send_item(OP_FRAME, 32'hFFFF_FFFF, '0);
    w = make_frame(16'h1234);
    send_item(OP_FRAME, w ^ 32'h0001_0000, '0);   // first parity broken
    send_item(OP_FRAME, w ^ 32'h0000_0001, '0);   // overall parity broken
    send_item(OP_FRAME, {w[31:28], 2'b10, w[25:0]}, '0);  // wrong status
    send_item(OP_LOAD, 32'hFFFF_FFFF, '0);
    send_item(OP_FRAME, make_frame(16'hFFFF), '0);
    settle();

    // Calibration: fill and wrap the window
    write_reg(REG_MODE, 32'd1);
    send_item(OP_FRAME, make_frame(16'h7FFF), '0);
    send_item(OP_FRAME, make_frame(16'h8000), '0);
    send_item(OP_LOAD, '0, 48'h0000_0100_0000);
    random_burst(120);
    // pause the sender until everything is back
    settle();
    random_burst(80);
    settle();

    // Integrate at the largest scale, with no idling on either side
    quiet = 1'b1;
    write_reg(REG_MODE, 32'd0);
    write_reg(REG_SCALE, 32'h7FFF_FFFF);
    random_burst(100);
    settle();
    quiet = 1'b0;

    // Most negative scale
    write_reg(REG_SCALE, 32'h8000_0000);
    random_burst(100);
    settle();

    // Re-enter calibration: the window carries over
    write_reg(REG_MODE, 32'd1);
    random_burst(140);
    settle();

    // Integrate at a random scale
    write_reg(REG_MODE, 32'd0);
    write_reg(REG_SCALE, $urandom);
    random_burst(100);
    @(negedge clk);
    sample_ch.valid <= 1'b0;
    settle();

    $display("covered %0d items: angle loads, bad frames, both modes, scale extremes,",
             items_sent);
    $display("a wrapped bias window and its reuse after leaving calibration");
    if (mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
